// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define XTR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("xtr assertion failed");

// Expression must never be true outside reset.
`define XTR_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("xtr forbidden condition seen");

`endif

// ===== rtl/xtr_pkg.sv =====
`timescale 1ns / 1ps
package xtr_pkg;

    localparam int COMP_W    = 32;
    localparam int COEF_W    = 18;
    localparam int COEF_FRAC = 14;
    localparam int ROW_W     = 3 * COEF_W;
    localparam int EFF_W     = 20;
    localparam int EFF_FRAC  = 10;
    localparam int OUT_W     = 32;
    localparam int PROD_W    = COEF_W + COMP_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int DOT_W     = ACC_W - COEF_FRAC;
    localparam int CFG_IDX_W = 3;

    localparam logic [ROW_W-1:0] ROW_RESET  = '0;
    localparam logic [ROW_W-1:0] GRAY_RESET = 54'd72982962376951;
    localparam logic [EFF_W-1:0] EFF_RESET  = 20'd187464;

    typedef enum logic [1:0] {
        ACT_XFORM = 2'd0,
        ACT_CLIP  = 2'd1,
        ACT_GRAY  = 2'd2,
        ACT_LUMA  = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_RED   = 3'd0,
        CFG_ROW_GREEN = 3'd1,
        CFG_ROW_BLUE  = 3'd2,
        CFG_GRAY      = 3'd3,
        CFG_EFFICACY  = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic    valid;
        t_action action;
    } t_ctl;

endpackage

// ===== rtl/xtr_lane.sv =====
`timescale 1ns / 1ps
module xtr_lane import xtr_pkg::*; (
    input  logic                     i_clk,
    input  logic [ROW_W-1:0]         i_row,
    input  logic signed [COMP_W-1:0] i_comp [3],
    output logic signed [DOT_W-1:0]  o_dot
);

    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (COEF_FRAC - 1);

    logic signed [COEF_W-1:0] w_coef [3];
    logic signed [PROD_W-1:0] n_prod [3];
    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [ACC_W-1:0]  n_sum;
    logic signed [DOT_W-1:0]  r_dot;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_coef[k] = $signed(i_row[k*COEF_W +: COEF_W]);
            n_prod[k] = PROD_W'(w_coef[k]) * PROD_W'(i_comp[k]);
        end
    end

    // round half up, then floor by dropping the fraction bits
    assign n_sum = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2]) + HALF_LSB;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_dot  <= n_sum[ACC_W-1:COEF_FRAC];
    end

    assign o_dot = r_dot;

endmodule

// ===== rtl/xtr_merge.sv =====
`timescale 1ns / 1ps
module xtr_merge import xtr_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic signed [DOT_W-1:0] i_dot [3],
    input  logic [EFF_W-1:0]        i_efficacy,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_first,
    output logic signed [OUT_W-1:0] o_second,
    output logic signed [OUT_W-1:0] o_third,
    output logic                    o_desat
);

    localparam int SAT_W = (DATA_WIDTH > OUT_W) ? OUT_W : DATA_WIDTH;
    localparam int LUM_W = DOT_W + EFF_W + 1;
    localparam int RND_W = LUM_W - EFF_FRAC;
    localparam logic signed [RND_W-1:0] SAT_HI =
        $signed({{(RND_W-SAT_W+1){1'b0}}, {(SAT_W-1){1'b1}}});
    localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [LUM_W-1:0] LUM_HALF = LUM_W'(1) <<< (EFF_FRAC - 1);

    function automatic logic signed [OUT_W-1:0] f_sat(input logic signed [RND_W-1:0] v);
        if (v > SAT_HI) begin
            return OUT_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            return OUT_W'(SAT_LO);
        end
        return v[OUT_W-1:0];
    endfunction

    t_ctl                    r_ctl;
    logic signed [LUM_W-1:0] r_lum;
    logic signed [DOT_W-1:0] r_dot [3];
    logic signed [LUM_W-1:0] w_lum_sum;
    logic signed [RND_W-1:0] w_lead;
    logic signed [OUT_W-1:0] w_sat [3];
    logic signed [OUT_W-1:0] n_out [3];
    logic                    n_desat;
    logic                    r_valid;
    logic signed [OUT_W-1:0] r_out [3];
    logic                    r_desat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_lum <= LUM_W'(i_dot[0]) * LUM_W'($signed({1'b0, i_efficacy}));
        r_dot <= i_dot;
    end

    assign w_lum_sum = r_lum + LUM_HALF;
    assign w_lead = (r_ctl.action == ACT_LUMA) ? w_lum_sum[LUM_W-1:EFF_FRAC]
                                               : RND_W'(r_dot[0]);

    always_comb begin
        w_sat[0] = f_sat(w_lead);
        w_sat[1] = f_sat(RND_W'(r_dot[1]));
        w_sat[2] = f_sat(RND_W'(r_dot[2]));
        n_out    = w_sat;
        n_desat  = 1'b0;
        unique case (r_ctl.action)
            ACT_XFORM: begin
                n_out = w_sat;
            end
            ACT_CLIP: begin
                for (int k = 0; k < 3; k++) begin
                    if (w_sat[k][OUT_W-1]) begin
                        n_out[k] = '0;
                        n_desat  = 1'b1;
                    end
                end
            end
            ACT_GRAY, ACT_LUMA: begin
                n_out[1] = '0;
                n_out[2] = '0;
            end
            default: begin
                n_out = w_sat;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_ctl.valid;
        end
        r_out   <= n_out;
        r_desat <= n_desat;
    end

    assign o_valid  = r_valid;
    assign o_first  = r_out[0];
    assign o_second = r_out[1];
    assign o_third  = r_out[2];
    assign o_desat  = r_desat;

endmodule

// ===== rtl/xyz_to_rgb_color_converter.sv =====
`timescale 1ns / 1ps
// XYZ-to-RGB colour converter: 3x3 matrix, clip, gray and luminance.
// Request channel: start with i_action and three signed Q16.16 components;
//   a request is taken on every edge where start is high and busy is low.
//   busy is low whenever reset is released, so one request per clock.
// Result channel: o_result_valid marks o_out_first/second/third and
//   o_desaturated for exactly one cycle. The receiver cannot stall;
//   results leave at the request rate.
// Throughput 1 request per cycle. Stages: coefficient
//   products in three dot-product lanes, lane sum and rounding, luminance
//   multiply by the efficacy, then saturation, clip and result register.
// Config: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data; write
//   only while no request is in flight. Unknown indexes are ignored.
// Reset (synchronous, i_rst_n low): matrix rows cleared, gray weights and
//   efficacy loaded with their nominal values, pipeline emptied. During
//   reset busy is high and o_cfg_ready is low.
module xyz_to_rgb_color_converter import xtr_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_action,
    input  logic signed [COMP_W-1:0] i_in_first,
    input  logic signed [COMP_W-1:0] i_in_second,
    input  logic signed [COMP_W-1:0] i_in_third,
    output logic                     o_result_valid,
    output logic signed [OUT_W-1:0]  o_out_first,
    output logic signed [OUT_W-1:0]  o_out_second,
    output logic signed [OUT_W-1:0]  o_out_third,
    output logic                     o_desaturated,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ROW_W-1:0]         i_cfg_data
);

    logic [ROW_W-1:0]         r_row_red;
    logic [ROW_W-1:0]         r_row_green;
    logic [ROW_W-1:0]         r_row_blue;
    logic [ROW_W-1:0]         r_gray;
    logic [EFF_W-1:0]         r_efficacy;
    logic                     w_accept;
    logic                     w_cfg_wr;
    t_action                  w_action;
    t_ctl                     r_ctl1;
    t_ctl                     r_ctl2;
    logic [ROW_W-1:0]         w_row0;
    logic signed [COMP_W-1:0] w_comp [3];
    logic signed [DOT_W-1:0]  w_dot [3];

    assign busy        = ~i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = start & ~busy;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign w_action    = t_action'(i_action);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_red   <= ROW_RESET;
            r_row_green <= ROW_RESET;
            r_row_blue  <= ROW_RESET;
            r_gray      <= GRAY_RESET;
            r_efficacy  <= EFF_RESET;
        end else if (w_cfg_wr) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ROW_RED:   r_row_red   <= i_cfg_data;
                CFG_ROW_GREEN: r_row_green <= i_cfg_data;
                CFG_ROW_BLUE:  r_row_blue  <= i_cfg_data;
                CFG_GRAY:      r_gray      <= i_cfg_data;
                CFG_EFFICACY:  r_efficacy  <= i_cfg_data[EFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= '{valid: w_accept, action: w_action};
            r_ctl2 <= r_ctl1;
        end
    end

    // lane 0 carries the gray weights for the gray and luminance requests
    assign w_row0 = (w_action == ACT_GRAY || w_action == ACT_LUMA) ? r_gray : r_row_red;

    assign w_comp[0] = i_in_first;
    assign w_comp[1] = i_in_second;
    assign w_comp[2] = i_in_third;

    xtr_lane u_lane_red (
        .i_clk  (i_clk),
        .i_row  (w_row0),
        .i_comp (w_comp),
        .o_dot  (w_dot[0])
    );

    xtr_lane u_lane_green (
        .i_clk  (i_clk),
        .i_row  (r_row_green),
        .i_comp (w_comp),
        .o_dot  (w_dot[1])
    );

    xtr_lane u_lane_blue (
        .i_clk  (i_clk),
        .i_row  (r_row_blue),
        .i_comp (w_comp),
        .o_dot  (w_dot[2])
    );

    xtr_merge #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_ctl2),
        .i_dot      (w_dot),
        .i_efficacy (r_efficacy),
        .o_valid    (o_result_valid),
        .o_first    (o_out_first),
        .o_second   (o_out_second),
        .o_third    (o_out_third),
        .o_desat    (o_desaturated)
    );

endmodule

// ===== rtl/xtr_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module xtr_checker import xtr_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic [1:0]              i_action,
    input logic                    o_result_valid,
    input logic signed [OUT_W-1:0] o_out_first,
    input logic signed [OUT_W-1:0] o_out_second,
    input logic signed [OUT_W-1:0] o_out_third,
    input logic                    o_desaturated
);

    // every result answers an earlier request
    `XTR_ASSERT(a_result_has_request, i_clk, i_rst_n, o_result_valid |-> $past(start && !busy, 4))

    // every request gives its result later
    `XTR_ASSERT(a_request_has_result, i_clk, i_rst_n, (start && !busy) |-> ##4 o_result_valid)

    // only the clip request may report clamping
    `XTR_NEVER(a_desat_only_clip, i_clk, i_rst_n, o_result_valid && o_desaturated && ($past(i_action, 4) != ACT_CLIP))

    // clipped results are never negative
    `XTR_ASSERT(a_clip_non_negative, i_clk, i_rst_n, (o_result_valid && ($past(i_action, 4) == ACT_CLIP)) |-> (!o_out_first[OUT_W-1] && !o_out_second[OUT_W-1] && !o_out_third[OUT_W-1]))

    // gray and luminance leave green and blue at zero
    `XTR_ASSERT(a_scalar_zero_tail, i_clk, i_rst_n, (o_result_valid && ($past(i_action, 4) == ACT_GRAY || $past(i_action, 4) == ACT_LUMA)) |-> (o_out_second == '0 && o_out_third == '0 && !o_desaturated))

endmodule

bind xyz_to_rgb_color_converter xtr_checker u_xtr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_action       (i_action),
    .o_result_valid (o_result_valid),
    .o_out_first    (o_out_first),
    .o_out_second   (o_out_second),
    .o_out_third    (o_out_third),
    .o_desaturated  (o_desaturated)
);

// ===== verif/xyz_to_rgb_color_converter_tb.sv =====
`timescale 1ns / 1ps
module xyz_to_rgb_color_converter_tb;
    import xtr_pkg::*;

    localparam int DATA_W  = 32;
    localparam int SAT_W   = (DATA_W > OUT_W) ? OUT_W : DATA_W;
    localparam int LATENCY = 4;
    localparam int ITEMS_PER_SETTING = 125;
    localparam int MAX_REPORTS = 10;

    localparam longint SAT_MAX = (longint'(1) <<< (SAT_W - 1)) - 1;
    localparam longint SAT_MIN = -SAT_MAX - 1;

    localparam int COEF_MAX = 2 ** (COEF_W - 1) - 1;
    localparam int COEF_MIN = -(2 ** (COEF_W - 1));

    localparam logic signed [COMP_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [COMP_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COMP_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum int {
        SET_NOMINAL,
        SET_MAX,
        SET_MIN,
        SET_ZERO,
        SET_RANDOM
    } t_setting;

    typedef struct {
        logic signed [OUT_W-1:0] red;
        logic signed [OUT_W-1:0] green;
        logic signed [OUT_W-1:0] blue;
        logic                    clamped;
    } t_colour;

    class colour_checker;
        logic [ROW_W-1:0] matrix_rows [3];
        logic [ROW_W-1:0] gray_row;
        logic [EFF_W-1:0] eff;
        t_colour          pending_colours [$];
        int               errors;
        int               checked;
        int               clamped;

        function new();
            matrix_rows[0] = ROW_RESET;
            matrix_rows[1] = ROW_RESET;
            matrix_rows[2] = ROW_RESET;
            gray_row = GRAY_RESET;
            eff      = EFF_RESET;
            errors   = 0;
            checked  = 0;
            clamped  = 0;
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
            case (idx)
                CFG_ROW_RED:   matrix_rows[0] = data;
                CFG_ROW_GREEN: matrix_rows[1] = data;
                CFG_ROW_BLUE:  matrix_rows[2] = data;
                CFG_GRAY:      gray_row = data;
                CFG_EFFICACY:  eff = data[EFF_W-1:0];
                default: ;
            endcase
        endfunction

        // exact products, one round-half-up to Q16.16
        function longint weighted_sum(logic [ROW_W-1:0] row, longint a, longint b, longint c);
            logic signed [COEF_W-1:0] w0, w1, w2;
            longint acc;
            w0  = row[COEF_W-1:0];
            w1  = row[2*COEF_W-1:COEF_W];
            w2  = row[ROW_W-1:2*COEF_W];
            acc = longint'(w0) * a + longint'(w1) * b + longint'(w2) * c;
            return (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        endfunction

        function logic signed [OUT_W-1:0] saturate(longint v);
            if (v > SAT_MAX) return SAT_MAX[OUT_W-1:0];
            if (v < SAT_MIN) return SAT_MIN[OUT_W-1:0];
            return v[OUT_W-1:0];
        endfunction

        function void note_request(t_action act, logic signed [COMP_W-1:0] a,
                                   logic signed [COMP_W-1:0] b, logic signed [COMP_W-1:0] c);
            t_colour                 res;
            logic signed [OUT_W-1:0] lanes [3];
            longint                  x, y, z, g, luma;
            x = a;
            y = b;
            z = c;
            res.red     = '0;
            res.green   = '0;
            res.blue    = '0;
            res.clamped = 1'b0;
            if (act == ACT_XFORM || act == ACT_CLIP) begin
                for (int k = 0; k < 3; k++) begin
                    lanes[k] = saturate(weighted_sum(matrix_rows[k], x, y, z));
                    if (act == ACT_CLIP && lanes[k] < 0) begin
                        lanes[k]    = '0;
                        res.clamped = 1'b1;
                    end
                end
                res.red   = lanes[0];
                res.green = lanes[1];
                res.blue  = lanes[2];
            end else begin
                g = weighted_sum(gray_row, x, y, z);
                if (act == ACT_GRAY) begin
                    res.red = saturate(g);
                end else begin
                    luma = (g * longint'({1'b0, eff}) + (longint'(1) <<< (EFF_FRAC - 1)))
                           >>> EFF_FRAC;
                    res.red = saturate(luma);
                end
            end
            pending_colours.push_back(res);
        endfunction

        function void check_result(logic signed [OUT_W-1:0] r, logic signed [OUT_W-1:0] g,
                                   logic signed [OUT_W-1:0] b, logic d);
            t_colour want;
            if (pending_colours.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result %h %h %h %b", $realtime, r, g, b, d);
                return;
            end
            want = pending_colours.pop_front();
            checked++;
            if (d === 1'b1) clamped++;
            if (r !== want.red || g !== want.green || b !== want.blue || d !== want.clamped) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result %0d expected %h %h %h %b, got %h %h %h %b",
                             $realtime, checked, want.red, want.green, want.blue,
                             want.clamped, r, g, b, d);
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               i_action;
    logic signed [COMP_W-1:0] i_in_first;
    logic signed [COMP_W-1:0] i_in_second;
    logic signed [COMP_W-1:0] i_in_third;
    logic                     o_result_valid;
    logic signed [OUT_W-1:0]  o_out_first;
    logic signed [OUT_W-1:0]  o_out_second;
    logic signed [OUT_W-1:0]  o_out_third;
    logic                     o_desaturated;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [ROW_W-1:0]         i_cfg_data;

    colour_checker board;
    int            requests_by_action [4];
    int            register_writes;
    int            settings_loaded;

    xyz_to_rgb_color_converter #(
        .DATA_WIDTH(DATA_W)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_in_first     (i_in_first),
        .i_in_second    (i_in_second),
        .i_in_third     (i_in_third),
        .o_result_valid (o_result_valid),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second),
        .o_out_third    (o_out_third),
        .o_desaturated  (o_desaturated),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1)
            board.check_result(o_out_first, o_out_second, o_out_third, o_desaturated);
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic signed [COMP_W-1:0] rand_component();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        if (pick < 8) return $urandom;
        case ($urandom_range(0, 4))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return -Q_ONE;
            default: return 1;
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] pack_row(int a, int b, int c);
        return {c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ROW_W-1:0];
    endfunction

    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(t_action act, logic signed [COMP_W-1:0] a,
                                logic signed [COMP_W-1:0] b, logic signed [COMP_W-1:0] c);
        start       <= 1'b1;
        i_action    <= act;
        i_in_first  <= a;
        i_in_second <= b;
        i_in_third  <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_request(act, a, b, c);
        requests_by_action[act]++;
        @(negedge i_clk);
    endtask

    task automatic pause_requests(int cycles);
        if (cycles > 0) begin
            start       <= 1'b0;
            i_action    <= 2'($urandom_range(0, 3));
            i_in_first  <= $urandom;
            i_in_second <= $urandom;
            i_in_third  <= $urandom;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // hold off until every request has come back, then let the pipe settle
    task automatic drain_requests();
        start <= 1'b0;
        while (board.pending_colours.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        board.note_register(idx, data);
        register_writes++;
        @(negedge i_clk);
    endtask

    task automatic load_setting(t_setting kind);
        logic [ROW_W-1:0] rows [3];
        logic [ROW_W-1:0] gray;
        logic [ROW_W-1:0] eff_data;
        case (kind)
            SET_NOMINAL: begin
                rows[0]  = pack_row(53094, -25186, -8169);
                rows[1]  = pack_row(-15874, 30733, 680);
                rows[2]  = pack_row(913, -3342, 17318);
                gray     = GRAY_RESET;
                // junk above the efficacy field must be dropped
                eff_data = rand_row();
                eff_data[EFF_W-1:0] = EFF_RESET;
            end
            SET_MAX: begin
                rows[0]  = pack_row(COEF_MAX, COEF_MAX, COEF_MAX);
                rows[1]  = rows[0];
                rows[2]  = rows[0];
                gray     = rows[0];
                eff_data = {ROW_W{1'b1}};
            end
            SET_MIN: begin
                rows[0]  = pack_row(COEF_MIN, COEF_MIN, COEF_MIN);
                rows[1]  = rows[0];
                rows[2]  = pack_row(COEF_MAX, COEF_MIN, COEF_MAX);
                gray     = rows[0];
                eff_data = '0;
            end
            SET_ZERO: begin
                rows[0]  = '0;
                rows[1]  = '0;
                rows[2]  = '0;
                gray     = '0;
                eff_data = rand_row();
            end
            default: begin
                rows[0]  = rand_row();
                rows[1]  = rand_row();
                rows[2]  = rand_row();
                gray     = rand_row();
                eff_data = rand_row();
            end
        endcase
        write_register(CFG_ROW_RED, rows[0]);
        write_register(CFG_ROW_GREEN, rows[1]);
        write_register(CFG_ROW_BLUE, rows[2]);
        write_register(CFG_GRAY, gray);
        write_register(CFG_EFFICACY, eff_data);
        write_register(CFG_IDX_W'($urandom_range(int'(CFG_EFFICACY) + 1,
                                                 (1 << CFG_IDX_W) - 1)), rand_row());
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    task automatic random_requests(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 2) drain_requests();
            else pause_requests(random_gap());
            send_request(t_action'($urandom_range(0, 3)),
                         rand_component(), rand_component(), rand_component());
        end
    endtask

    initial begin
        t_setting plan [8];
        board = new();
        register_writes = 0;
        settings_loaded = 0;
        for (int k = 0; k < 4; k++) requests_by_action[k] = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_action    = ACT_XFORM;
        i_in_first  = '0;
        i_in_second = '0;
        i_in_third  = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ROW_RED;
        i_cfg_data  = '0;
        plan = '{SET_MAX, SET_MIN, SET_ZERO, SET_NOMINAL,
                 SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_RANDOM};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // power-up register values
        send_request(ACT_XFORM, Q_ONE, Q_ONE, Q_ONE);
        send_request(ACT_CLIP, -Q_ONE, Q_ONE, Q_ONE);
        send_request(ACT_GRAY, Q_ONE, 2 * Q_ONE, Q_ONE);
        send_request(ACT_LUMA, Q_ONE, Q_ONE, Q_ONE);
        drain_requests();

        load_setting(SET_NOMINAL);
        send_request(ACT_XFORM, 0, 0, 0);
        send_request(ACT_XFORM, Q_ONE, Q_ONE, Q_ONE);
        send_request(ACT_XFORM, Q_MAX, Q_MAX, Q_MAX);
        send_request(ACT_XFORM, Q_MIN, Q_MIN, Q_MIN);
        send_request(ACT_XFORM, Q_MAX, Q_MIN, Q_MAX);
        send_request(ACT_XFORM, 1, -1, 1);
        send_request(ACT_CLIP, Q_ONE, 0, 0);
        send_request(ACT_CLIP, 0, Q_ONE, 0);
        send_request(ACT_CLIP, Q_ONE, Q_ONE, Q_ONE);
        send_request(ACT_CLIP, Q_MIN, Q_MAX, Q_MIN);
        send_request(ACT_CLIP, -Q_ONE, -Q_ONE, -Q_ONE);
        send_request(ACT_GRAY, Q_MAX, Q_MAX, Q_MAX);
        send_request(ACT_GRAY, Q_MIN, Q_MIN, Q_MIN);
        send_request(ACT_GRAY, Q_ONE, Q_ONE, Q_ONE);
        send_request(ACT_GRAY, -1, 0, 1);
        send_request(ACT_LUMA, Q_ONE, Q_ONE, Q_ONE);
        send_request(ACT_LUMA, Q_MAX, Q_MAX, Q_MAX);
        send_request(ACT_LUMA, Q_MIN, Q_MIN, Q_MIN);
        send_request(ACT_LUMA, -Q_ONE, 0, Q_ONE);
        send_request(ACT_LUMA, 1, 1, 1);
        drain_requests();

        foreach (plan[p]) begin
            load_setting(plan[p]);
            random_requests(ITEMS_PER_SETTING);
            drain_requests();
        end

        $display("Ran %0d requests: %0d transform, %0d clip, %0d gray, %0d luminance; %0d clamped.",
                 board.checked, requests_by_action[ACT_XFORM], requests_by_action[ACT_CLIP],
                 requests_by_action[ACT_GRAY], requests_by_action[ACT_LUMA], board.clamped);
        $display("%0d register writes over %0d coefficient settings, %0d failures.",
                 register_writes, settings_loaded, board.errors);
        if (board.errors == 0 && board.pending_colours.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
